// ----- sv/qrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

	localparam int COEF_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int LIM_W    = 16;
	localparam int MAG_W    = COEF_W;
	localparam int PROD_W   = 2 * MAG_W;
	localparam int DISC_W   = PROD_W + 3;
	localparam int RAD_W    = PROD_W + 2;
	localparam int SQ_STEPS = RAD_W / 2;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int SREM_W   = ROOT_W + 2;
	localparam int N_W      = ROOT_W + 2;
	localparam int NMAG_W   = ROOT_W + 1;
	localparam int NUM_W    = NMAG_W + FRAC_W;
	localparam int DIV_W    = MAG_W + 1;
	localparam int DREM_W   = DIV_W + 1;
	localparam int Q_W      = NUM_W;

	typedef enum logic [2:0] {
		ST_NOT_QUAD = 3'd0,
		ST_ONE      = 3'd1,
		ST_TWO      = 3'd2,
		ST_NO_REAL  = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic              not_quad;
		logic              no_real;
		logic              d_zero;
		logic              a_neg;
		logic              b_neg;
		logic [MAG_W-1:0]  b_mag;
		logic [DIV_W-1:0]  two_a;
	} sq_side_t;

	typedef struct packed {
		logic              not_quad;
		logic              no_real;
		logic              d_zero;
		logic [1:0]        neg;
		logic [DIV_W-1:0]  two_a;
	} dv_side_t;

endpackage
`default_nettype wire

// ----- sv/quadratic_root_solver_unit.sv -----
// Throughput: one request per clock; busy is always low.
// The square root takes one cell per root bit (33), the two divisions one cell
// per quotient bit (50), plus decode, multiply, discriminant, numerator and output.
// The receiver cannot stall; each result shows for exactly one cycle.
// Reset clears the valid chain and sets zero_limit to 1.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [qrs_pkg::COEF_W-1:0] a_coef,
	input  wire logic signed [qrs_pkg::COEF_W-1:0] b_coef,
	input  wire logic signed [qrs_pkg::COEF_W-1:0] c_coef,
	input  wire logic                              cfg_we,
	input  wire logic [qrs_pkg::LIM_W-1:0]         cfg_wdata,
	output logic                                   done,
	output logic [2:0]                             status,
	output logic signed [qrs_pkg::COEF_W-1:0]      root_one,
	output logic signed [qrs_pkg::COEF_W-1:0]      root_two
);

	localparam int SQ = qrs_pkg::SQ_STEPS;
	localparam int DV = qrs_pkg::Q_W;

	logic [qrs_pkg::LIM_W-1:0] zero_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_limit_q <= qrs_pkg::LIM_W'(1);
		end else if (cfg_we) begin
			zero_limit_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// decode
	logic [qrs_pkg::MAG_W-1:0] am, bm, cm;
	assign am = a_coef[qrs_pkg::COEF_W-1] ? -a_coef : a_coef;
	assign bm = b_coef[qrs_pkg::COEF_W-1] ? -b_coef : b_coef;
	assign cm = c_coef[qrs_pkg::COEF_W-1] ? -c_coef : c_coef;

	logic                      v_s1, v_s2, v_s3;
	logic [qrs_pkg::MAG_W-1:0] am_s1, bm_s1, cm_s1;
	logic                      an_s1, bn_s1, cn_s1, nq_s1;
	logic [qrs_pkg::PROD_W-1:0] bb_s2, ac_s2;
	logic                      an_s2, bn_s2, cn_s2, nq_s2;
	logic [qrs_pkg::MAG_W-1:0] am_s2, bm_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		am_s1 <= am;
		bm_s1 <= bm;
		cm_s1 <= cm;
		an_s1 <= a_coef[qrs_pkg::COEF_W-1];
		bn_s1 <= b_coef[qrs_pkg::COEF_W-1];
		cn_s1 <= c_coef[qrs_pkg::COEF_W-1];
		nq_s1 <= (am == '0) || (am < qrs_pkg::MAG_W'(zero_limit_q));
		bb_s2 <= bm_s1 * bm_s1;
		ac_s2 <= am_s1 * cm_s1;
		an_s2 <= an_s1;
		bn_s2 <= bn_s1;
		cn_s2 <= cn_s1;
		nq_s2 <= nq_s1;
		am_s2 <= am_s1;
		bm_s2 <= bm_s1;
	end

	// discriminant b*b - 4ac, exact
	logic [qrs_pkg::DISC_W-1:0] bb_x, ac4_x, disc;
	assign bb_x  = {3'b000, bb_s2};
	assign ac4_x = {1'b0, ac_s2, 2'b00};
	assign disc  = (an_s2 != cn_s2) ? bb_x + ac4_x : bb_x - ac4_x;

	logic [qrs_pkg::RAD_W-1:0]  sq_rad  [0:SQ];
	logic [qrs_pkg::SREM_W-1:0] sq_rem  [0:SQ];
	logic [qrs_pkg::ROOT_W-1:0] sq_root [0:SQ];
	qrs_pkg::sq_side_t          sq_side [0:SQ];
	logic [SQ:0]                sq_v;

	assign sq_v[0] = v_s3;

	always_ff @(posedge clk) begin
		sq_rad[0]           <= disc[qrs_pkg::RAD_W-1:0];
		sq_rem[0]           <= '0;
		sq_root[0]          <= '0;
		sq_side[0].not_quad <= nq_s2;
		sq_side[0].no_real  <= disc[qrs_pkg::DISC_W-1];
		sq_side[0].d_zero   <= disc == '0;
		sq_side[0].a_neg    <= an_s2;
		sq_side[0].b_neg    <= bn_s2;
		sq_side[0].b_mag    <= bm_s2;
		sq_side[0].two_a    <= {am_s2, 1'b0};
	end

	for (genvar g = 0; g < SQ; g++) begin : g_sq
		qrs_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (sq_v[g]),
			.rad    (sq_rad[g]),
			.rem    (sq_rem[g]),
			.root   (sq_root[g]),
			.side   (sq_side[g]),
			.vld_q  (sq_v[g+1]),
			.rad_q  (sq_rad[g+1]),
			.rem_q  (sq_rem[g+1]),
			.root_q (sq_root[g+1]),
			.side_q (sq_side[g+1])
		);
	end

	// numerators -b + s and -b - s
	qrs_pkg::sq_side_t                 sd;
	logic signed [qrs_pkg::N_W-1:0]    neg_b, s_x, n1, n2;
	logic [qrs_pkg::NMAG_W-1:0]        m1, m2;
	assign sd    = sq_side[SQ];
	assign s_x   = qrs_pkg::N_W'(sq_root[SQ]);
	assign neg_b = sd.b_neg ? qrs_pkg::N_W'(sd.b_mag) : -qrs_pkg::N_W'(sd.b_mag);
	assign n1    = neg_b + s_x;
	assign n2    = neg_b - s_x;
	assign m1    = n1[qrs_pkg::N_W-1] ? qrs_pkg::NMAG_W'(-n1) : qrs_pkg::NMAG_W'(n1);
	assign m2    = n2[qrs_pkg::N_W-1] ? qrs_pkg::NMAG_W'(-n2) : qrs_pkg::NMAG_W'(n2);

	logic [1:0][qrs_pkg::NUM_W-1:0]  dv_num [0:DV];
	logic [1:0][qrs_pkg::DREM_W-1:0] dv_rem [0:DV];
	logic [1:0][qrs_pkg::Q_W-1:0]    dv_quo [0:DV];
	qrs_pkg::dv_side_t               dv_side [0:DV];
	logic [DV:0]                     dv_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else begin
			dv_v[0] <= sq_v[SQ];
		end
	end

	always_ff @(posedge clk) begin
		dv_num[0][0]        <= {m1, {qrs_pkg::FRAC_W{1'b0}}};
		dv_num[0][1]        <= {m2, {qrs_pkg::FRAC_W{1'b0}}};
		dv_rem[0]           <= '0;
		dv_quo[0]           <= '0;
		dv_side[0].not_quad <= sd.not_quad;
		dv_side[0].no_real  <= sd.no_real;
		dv_side[0].d_zero   <= sd.d_zero;
		dv_side[0].neg[0]   <= n1[qrs_pkg::N_W-1] != sd.a_neg;
		dv_side[0].neg[1]   <= n2[qrs_pkg::N_W-1] != sd.a_neg;
		dv_side[0].two_a    <= sd.two_a;
	end

	for (genvar g = 0; g < DV; g++) begin : g_dv
		qrs_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (dv_v[g]),
			.num    (dv_num[g]),
			.rem    (dv_rem[g]),
			.quo    (dv_quo[g]),
			.side   (dv_side[g]),
			.vld_q  (dv_v[g+1]),
			.num_q  (dv_num[g+1]),
			.rem_q  (dv_rem[g+1]),
			.quo_q  (dv_quo[g+1]),
			.side_q (dv_side[g+1])
		);
	end

	// range check, sign and status
	localparam logic [qrs_pkg::Q_W-1:0] LIMIT = qrs_pkg::Q_W'(1) << (qrs_pkg::COEF_W - 1);

	qrs_pkg::dv_side_t                fs;
	logic [1:0]                       ok;
	logic [1:0][qrs_pkg::COEF_W-1:0]  rv;
	qrs_pkg::status_t                 st;
	assign fs = dv_side[DV];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			ok[i] = !((dv_quo[DV][i] > LIMIT) || (dv_quo[DV][i] == LIMIT && !fs.neg[i]));
			rv[i] = fs.neg[i] ? -dv_quo[DV][i][qrs_pkg::COEF_W-1:0]
			                  : dv_quo[DV][i][qrs_pkg::COEF_W-1:0];
		end
		priority if (fs.not_quad) begin
			st = qrs_pkg::ST_NOT_QUAD;
		end else if (fs.no_real) begin
			st = qrs_pkg::ST_NO_REAL;
		end else if (fs.d_zero) begin
			st = ok[0] ? qrs_pkg::ST_ONE : qrs_pkg::ST_OVERFLOW;
		end else begin
			st = (ok[0] && ok[1]) ? qrs_pkg::ST_TWO : qrs_pkg::ST_OVERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v[DV];
		end
	end

	always_ff @(posedge clk) begin
		status   <= st;
		root_one <= (st == qrs_pkg::ST_ONE || st == qrs_pkg::ST_TWO) ? rv[0] : '0;
		root_two <= (st == qrs_pkg::ST_TWO) ? rv[1] : '0;
	end

endmodule
`default_nettype wire

// ----- sv/qrs_sqrt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vld,
	input  wire logic [qrs_pkg::RAD_W-1:0]     rad,
	input  wire logic [qrs_pkg::SREM_W-1:0]    rem,
	input  wire logic [qrs_pkg::ROOT_W-1:0]    root,
	input  wire qrs_pkg::sq_side_t             side,
	output logic                               vld_q,
	output logic [qrs_pkg::RAD_W-1:0]          rad_q,
	output logic [qrs_pkg::SREM_W-1:0]         rem_q,
	output logic [qrs_pkg::ROOT_W-1:0]         root_q,
	output qrs_pkg::sq_side_t                  side_q
);

	logic [qrs_pkg::SREM_W-1:0] rem_sh;
	logic [qrs_pkg::SREM_W-1:0] trial;
	logic                       ge;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem[qrs_pkg::SREM_W-3:0], rad[qrs_pkg::RAD_W-1 -: 2]};
	assign trial  = {root, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad[qrs_pkg::RAD_W-3:0], 2'b00};
		rem_q  <= ge ? rem_sh - trial : rem_sh;
		root_q <= {root[qrs_pkg::ROOT_W-2:0], ge};
		side_q <= side;
	end

endmodule
`default_nettype wire

// ----- sv/qrs_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               vld,
	input  wire logic [1:0][qrs_pkg::NUM_W-1:0]     num,
	input  wire logic [1:0][qrs_pkg::DREM_W-1:0]    rem,
	input  wire logic [1:0][qrs_pkg::Q_W-1:0]       quo,
	input  wire qrs_pkg::dv_side_t                  side,
	output logic                                    vld_q,
	output logic [1:0][qrs_pkg::NUM_W-1:0]          num_q,
	output logic [1:0][qrs_pkg::DREM_W-1:0]         rem_q,
	output logic [1:0][qrs_pkg::Q_W-1:0]            quo_q,
	output qrs_pkg::dv_side_t                       side_q
);

	logic [1:0][qrs_pkg::DREM_W-1:0] rem_sh;
	logic [1:0][qrs_pkg::DREM_W-1:0] rem_nx;
	logic [1:0]                      ge;
	logic [qrs_pkg::DREM_W-1:0]      dvs;

	assign dvs = {1'b0, side.two_a};

	// one restoring step per lane
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rem_sh[i] = {rem[i][qrs_pkg::DREM_W-2:0], num[i][qrs_pkg::NUM_W-1]};
			ge[i]     = rem_sh[i] >= dvs;
			rem_nx[i] = ge[i] ? rem_sh[i] - dvs : rem_sh[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			num_q[i] <= {num[i][qrs_pkg::NUM_W-2:0], 1'b0};
			rem_q[i] <= rem_nx[i];
			quo_q[i] <= {quo[i][qrs_pkg::Q_W-2:0], ge[i]};
		end
		side_q <= side;
	end

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;

	typedef struct {
		qrs_pkg::status_t          st;
		logic [qrs_pkg::COEF_W-1:0] r1;
		logic [qrs_pkg::COEF_W-1:0] r2;
	} roots_t;

	class root_scoreboard;
		roots_t      pending[$];
		logic [15:0] zero_limit = 16'd1;
		int          errors = 0;
		int          seen[5] = '{0, 0, 0, 0, 0};

		function logic [127:0] isqrt(logic [127:0] d);
			logic [127:0] r, t;
			r = 0;
			for (int i = 40; i >= 0; i--) begin
				t = r | (128'd1 << i);
				if (t * t <= d)
					r = t;
			end
			return r;
		endfunction

		// quotient of (n << FRAC_W) by 2a, truncated toward zero; 0 on range overflow
		function bit scale_root(logic [127:0] n, bit a_neg, logic [127:0] two_a,
				output logic [qrs_pkg::COEF_W-1:0] raw);
			logic [127:0] mag, q, lim;
			bit neg;
			mag = n[127] ? -n : n;
			neg = n[127] != a_neg;
			q = (mag << qrs_pkg::FRAC_W) / two_a;
			lim = 128'd1 << (qrs_pkg::COEF_W - 1);
			raw = '0;
			if (q > lim || (q == lim && !neg))
				return 0;
			raw = neg ? qrs_pkg::COEF_W'(-q) : qrs_pkg::COEF_W'(q);
			return 1;
		endfunction

		function void note(logic [31:0] a, logic [31:0] b, logic [31:0] c);
			logic [127:0] am, bm, cm, d, nb, s, two_a;
			bit an, bn, cn, ok1, ok2;
			roots_t e;
			an = a[31]; bn = b[31]; cn = c[31];
			am = an ? (128'd1 << 32) - a : a;
			bm = bn ? (128'd1 << 32) - b : b;
			cm = cn ? (128'd1 << 32) - c : c;
			e.st = qrs_pkg::ST_NOT_QUAD; e.r1 = '0; e.r2 = '0;
			if (am != 0 && am >= zero_limit) begin
				d = (an != cn) ? bm * bm + 4 * am * cm : bm * bm - 4 * am * cm;
				if (d[127]) begin
					e.st = qrs_pkg::ST_NO_REAL;
				end else begin
					nb = bn ? bm : -bm;
					two_a = am << 1;
					if (d == 0) begin
						e.st = scale_root(nb, an, two_a, e.r1) ? qrs_pkg::ST_ONE
						                                       : qrs_pkg::ST_OVERFLOW;
					end else begin
						s = isqrt(d);
						ok1 = scale_root(nb + s, an, two_a, e.r1);
						ok2 = scale_root(nb - s, an, two_a, e.r2);
						e.st = (ok1 && ok2) ? qrs_pkg::ST_TWO : qrs_pkg::ST_OVERFLOW;
					end
					if (e.st == qrs_pkg::ST_OVERFLOW) begin
						e.r1 = '0; e.r2 = '0;
					end
				end
			end
			seen[e.st]++;
			pending.push_back(e);
		endfunction

		function void check(logic [2:0] st, logic [31:0] r1, logic [31:0] r2);
			roots_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result status=%0d r1=%h r2=%h", $time, st, r1, r2);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (r1 !== e.r1) begin
				$display("%0t: root_one expected %h actual %h", $time, e.r1, r1);
				errors++;
			end
			if (r2 !== e.r2) begin
				$display("%0t: root_two expected %h actual %h", $time, e.r2, r2);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, cfg_we, busy, done;
	logic signed [qrs_pkg::COEF_W-1:0] a_coef, b_coef, c_coef, root_one, root_two;
	logic [qrs_pkg::LIM_W-1:0] cfg_wdata;
	logic [2:0] status;
	root_scoreboard sb = new();
	int requests = 0;

	quadratic_root_solver_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_coef(a_coef), .b_coef(b_coef), .c_coef(c_coef),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .status(status), .root_one(root_one), .root_two(root_two)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (start && !busy) begin
			sb.note(a_coef, b_coef, c_coef);
			requests++;
		end
		if (done)
			sb.check(status, root_one, root_two);
	end

	task automatic push(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		start <= 1'b1;
		a_coef <= a; b_coef <= b; c_coef <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// let the last request get noted before watching the queue empty
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic set_limit(logic [15:0] v);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.zero_limit = v;
	endtask

	// random equation with a chosen shape: exact double root, small roots or raw noise
	task automatic push_random();
		logic [31:0] a, b, c;
		int p, q;
		case ($urandom_range(0, 5))
			0: begin
				p = $urandom_range(1, 1000); q = $urandom_range(0, 1000);
				if ($urandom_range(0, 1)) p = -p;
				if ($urandom_range(0, 1)) q = -q;
				a = p; b = 2 * p * q; c = p * q * q;
			end
			1, 2: begin
				a = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000);
				if ($urandom_range(0, 1)) a = -a;
				b = $urandom; c = $urandom;
				if ($urandom_range(0, 1)) b = $signed(b) >>> $urandom_range(0, 20);
				if ($urandom_range(0, 1)) c = $signed(c) >>> $urandom_range(0, 20);
			end
			3: begin
				a = $urandom_range(0, 70000); b = $urandom; c = $urandom;
				if ($urandom_range(0, 1)) a = -a;
			end
			default: begin
				a = $urandom; b = $urandom; c = $urandom;
			end
		endcase
		push(a, b, c);
	endtask

	initial begin
		arst_n = 1'b0;
		start <= 1'b0; cfg_we <= 1'b0; cfg_wdata <= '0;
		a_coef <= '0; b_coef <= '0; c_coef <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero and tiny a, extremes, double root, complex, overflow
		push(32'd0, 32'd5, 32'd7);
		push(32'd1, 32'd0, 32'd0);
		push(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
		push(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
		push(32'h0001_0000, 32'd0, 32'h0001_0000);
		push(32'h0000_0002, 32'h7FFF_FFFF, 32'd0);
		push(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		push(32'h0000_0001, 32'h8000_0000, 32'h4000_0000);
		push(32'h0001_0000, 32'h0000_0000, 32'h8000_0000);
		push(32'hFFFF_0000, 32'h0004_0000, 32'hFFFC_0000);
		push(32'h0000_8000, 32'h0000_0000, 32'h8000_0000);
		set_limit(16'd0);
		push(32'd0, 32'd1, 32'd1);
		push(32'd1, 32'd2, 32'd1);
		push(32'hFFFF_FFFF, 32'd3, 32'd0);
		set_limit(16'hFFFF);
		push(32'h0000_FFFE, 32'd4, 32'd1);
		push(32'h0000_FFFF, 32'd4, 32'd1);
		push(32'hFFFF_0001, 32'd4, 32'd1);
		push(32'hFFFF_0002, 32'd4, 32'd1);

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_limit(16'd1);
				1: set_limit(16'd0);
				2: set_limit(16'hFFFF);
				default: set_limit(16'($urandom_range(0, 65535)));
			endcase
			for (int i = 0; i < 200; i++) begin
				push_random();
				if ($urandom_range(0, 2) != 0)
					pause();
				if (i == 100)
					drain();
			end
		end
		drain();
		start <= 1'b0;
		repeat (100) @(posedge clk);
		$display("%0d requests over 9 zero_limit settings; status counts:", requests);
		$display("  not quadratic %0d, one %0d, two %0d, no real %0d, overflow %0d",
			sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4]);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
